// ===== hdl/sadc_pkg.sv =====
// Shared widths, sequence constants and payload types of the serial converter reader.
package sadc_pkg;

    localparam int SAMPLE_W          = 8;
    localparam int HALF_W            = 8;
    localparam int STEP_W            = 5;
    localparam int AVERAGE_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd2;

    // Sequence phases with a meaning of their own.
    localparam logic [STEP_W-1:0] PHASE_ODD_LOW    = 5'd4;
    localparam logic [STEP_W-1:0] PHASE_ODD_HIGH   = 5'd5;
    localparam logic [STEP_W-1:0] PHASE_FIRST_DATA = 5'd7;
    localparam logic [STEP_W-1:0] PHASE_LAST       = 5'd22;

    typedef struct packed {
        logic start_req;
        logic adc_dout;
    } t_in;

    typedef struct packed {
        logic                chip_select_n;
        logic                serial_clock;
        logic                serial_din;
        logic                busy_res;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] raw_sample;
    } t_mid;

    typedef struct packed {
        logic                chip_select_n;
        logic                serial_clock;
        logic                serial_din;
        logic                busy_res;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] raw_sample;
        logic [SAMPLE_W-1:0] filtered_sample;
    } t_out;

endpackage

// ===== hdl/serial_adc_reader_moving_average.sv =====
// Each pushed item is one timing tick of the serial converter sequence and yields exactly one
// result, at one tick per clock cycle while the queue is not full; an accepted tick sits on
// the result ports once it has passed the queue write, then the filter update, then the
// division, and it can be popped from there.
// A start request while idle opens a 23-phase sequence of half_period_ticks ticks per phase;
// its last tick carries sample_valid with the raw sample and the floor of the mean of the last
// AVERAGE_DEPTH samples. The first sample after reset fills the whole history, so there is no
// clearing pass. The configuration channel is always ready and should be written while idle.
module serial_adc_reader_moving_average
    import sadc_pkg::*;
#(
    parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_in               i_item,
    output logic              empty,
    input  logic              pop,
    output t_out              o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [HALF_W-1:0] i_cfg_data
);

    t_mid w_front_item;
    t_mid w_queue_item;
    logic w_accept;
    logic w_queue_empty;
    logic w_back_ready;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    sadc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_item      (w_front_item)
    );

    sadc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_item),
        .o_full  (full),
        .o_empty (w_queue_empty),
        .i_pop   (w_back_ready),
        .o_data  (w_queue_item)
    );

    sadc_filter #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_queue_empty),
        .o_ready  (w_back_ready),
        .i_item   (w_queue_item),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

`ifndef SYNTH
    // The queue can only fill up while the filter is stalled on a waiting result.
    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full while no result waits");

    // A finished sample is only reported inside an active sequence.
    a_sample_in_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.sample_valid) |-> (o_result.busy_res && !o_result.chip_select_n))
        else $error("sample reported outside a sequence");

    // Ticks without a sample carry zero sample fields.
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.sample_valid)
            |-> (o_result.raw_sample == '0 && o_result.filtered_sample == '0))
        else $error("sample fields not zero on a tick without a sample");
`endif

endmodule

// ===== hdl/sadc_front.sv =====
// Conversion sequencer: drives the serial lines for each tick and shifts in the sample.
module sadc_front
    import sadc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in               i_item,
    input  logic              i_cfg_write,
    input  logic [HALF_W-1:0] i_cfg_data,
    output t_mid              o_item
);

    logic [STEP_W-1:0]   r_step, n_step;
    logic [HALF_W-1:0]   r_div, n_div;
    logic [SAMPLE_W-1:0] r_shift, n_shift;
    logic [HALF_W-1:0]   r_half;

    logic                idle;
    logic                active;
    logic [STEP_W-1:0]   phase;
    logic [HALF_W-1:0]   div_cur;
    logic [SAMPLE_W-1:0] shift_cur;
    logic [HALF_W-1:0]   half;
    logic                last;
    logic                sclk;
    logic                done;

    always_comb begin
        idle      = (r_step == '0);
        active    = !idle || i_item.start_req;
        phase     = idle ? '0 : r_step - 5'd1;
        div_cur   = idle ? '0 : r_div;
        shift_cur = idle ? '0 : r_shift;
        // A zero half period behaves as a single tick.
        half      = (r_half == '0) ? 8'd1 : r_half;
        last      = ({1'b0, div_cur} + 9'd1) >= {1'b0, half};
        sclk      = active && phase[0];
        done      = active && last && (phase == PHASE_LAST);

        n_shift = shift_cur;
        if (sclk && last && (phase >= PHASE_FIRST_DATA)) begin
            n_shift = {shift_cur[SAMPLE_W-2:0], i_item.adc_dout};
        end

        n_step = r_step;
        n_div  = r_div;
        if (active) begin
            if (last) begin
                n_step = done ? '0 : phase + 5'd2;
                n_div  = '0;
            end else begin
                n_step = idle ? 5'd1 : r_step;
                n_div  = div_cur + 8'd1;
            end
        end

        o_item.chip_select_n = !active;
        o_item.serial_clock  = sclk;
        o_item.serial_din    = !(active && ((phase == PHASE_ODD_LOW) ||
                                            (phase == PHASE_ODD_HIGH)));
        o_item.busy_res      = active;
        o_item.sample_valid  = done;
        o_item.raw_sample    = done ? n_shift : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_div   <= '0;
            r_shift <= '0;
            r_half  <= HALF_PERIOD_RESET;
        end else begin
            if (i_cfg_write) begin
                r_half <= i_cfg_data;
            end
            if (i_accept && active) begin
                r_step  <= n_step;
                r_div   <= n_div;
                r_shift <= n_shift;
            end
        end
    end

endmodule

// ===== hdl/sadc_queue.sv =====
// Short queue of sequencer results between the sequencer and the filter.
module sadc_queue
    import sadc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_mid o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_mid             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/sadc_filter.sv =====
// Moving-average filter: history update, running total and division by the depth.
module sadc_filter
    import sadc_pkg::*;
#(
    parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_mid i_item,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_result
);

    localparam int SLOT_W      = $clog2(AVERAGE_DEPTH);
    localparam int TOTAL_W     = SAMPLE_W + SLOT_W;
    localparam int MULT_W      = TOTAL_W + 1;
    localparam int PROD_W      = TOTAL_W + MULT_W;
    // Rounded-up reciprocal; exact floor division for every total below 2**TOTAL_W.
    localparam int RECIP_SHIFT = TOTAL_W + SLOT_W;
    localparam int RECIP_INT   = ((1 << RECIP_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam logic [MULT_W-1:0] RECIP_MULT = MULT_W'(RECIP_INT);

    logic [SAMPLE_W-1:0] r_hist [AVERAGE_DEPTH];
    logic [SLOT_W-1:0]   r_slot;
    logic                r_primed;
    logic [TOTAL_W-1:0]  r_total;

    logic                r_s1_valid;
    t_mid                r_s1_item;
    logic                r_s1_first;
    logic                r_s2_valid;
    t_out                r_s2_out;

    logic                s2_ready;
    logic                take;
    logic                sample_in;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] quotient;

    assign s2_ready  = !r_s2_valid || i_pop;
    assign o_ready   = !r_s1_valid || s2_ready;
    assign take      = i_valid && o_ready;
    assign sample_in = take && i_item.sample_valid;
    assign o_empty   = !r_s2_valid;
    assign o_result  = r_s2_out;

    assign product  = PROD_W'(r_total) * PROD_W'(RECIP_MULT);
    assign quotient = product[RECIP_SHIFT +: SAMPLE_W];

    // The first sample fills the whole history, so no entry is read unwritten.
    always_ff @(posedge i_clk) begin
        if (sample_in) begin
            if (!r_primed) begin
                for (int i = 0; i < AVERAGE_DEPTH; i++) begin
                    r_hist[i] <= i_item.raw_sample;
                end
            end else begin
                r_hist[r_slot] <= i_item.raw_sample;
            end
        end
        if (take) begin
            r_s1_item  <= i_item;
            r_s1_first <= !r_primed;
        end
        if (r_s1_valid && s2_ready) begin
            r_s2_out.chip_select_n   <= r_s1_item.chip_select_n;
            r_s2_out.serial_clock    <= r_s1_item.serial_clock;
            r_s2_out.serial_din      <= r_s1_item.serial_din;
            r_s2_out.busy_res        <= r_s1_item.busy_res;
            r_s2_out.sample_valid    <= r_s1_item.sample_valid;
            r_s2_out.raw_sample      <= r_s1_item.raw_sample;
            if (!r_s1_item.sample_valid) begin
                r_s2_out.filtered_sample <= '0;
            end else if (r_s1_first) begin
                r_s2_out.filtered_sample <= r_s1_item.raw_sample;
            end else begin
                r_s2_out.filtered_sample <= quotient;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_primed   <= 1'b0;
            r_total    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (sample_in) begin
                if (!r_primed) begin
                    r_primed <= 1'b1;
                    r_slot   <= '0;
                    r_total  <= TOTAL_W'(i_item.raw_sample) * TOTAL_W'(AVERAGE_DEPTH);
                end else begin
                    r_total <= r_total - TOTAL_W'(r_hist[r_slot])
                               + TOTAL_W'(i_item.raw_sample);
                    r_slot  <= (r_slot == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                end
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the serial converter reader with its moving-average filter.
`timescale 1ns / 100ps

module tb;
    import sadc_pkg::*;

    localparam int DEPTH       = AVERAGE_DEPTH_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DOUT_RANDOM = 0;
    localparam int DOUT_ZEROS  = 1;
    localparam int DOUT_ONES   = 2;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    t_in               i_item = '0;
    logic              empty;
    logic              pop = 1'b0;
    t_out              o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [HALF_W-1:0] i_cfg_data = '0;

    serial_adc_reader_moving_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shadow copy of the sequencer and filter state.
    logic [HALF_W-1:0]   half_period;
    logic [STEP_W-1:0]   seq_step;
    logic [7:0]          tick_div;
    logic [SAMPLE_W-1:0] shift_reg;
    logic [SAMPLE_W-1:0] history [DEPTH];
    int                  write_slot;
    logic                primed;
    int                  running_total;

    t_in  tick_queue[$];
    t_out predicted_outputs[$];

    int ticks_sent;
    int results_checked;
    int conversions_seen;
    int cfg_writes;
    int mismatches;
    int burst_left;
    int gap_left;
    int idle_cycles;
    logic [9:0] pop_cycle;

    function automatic t_out convert_tick(input t_in tk);
        t_out                r;
        logic [HALF_W-1:0]   hp_eff;
        logic [STEP_W-1:0]   phase;
        logic                last_tick;
        r               = '0;
        r.chip_select_n = 1'b1;
        r.serial_din    = 1'b1;
        hp_eff          = (half_period == '0) ? 8'd1 : half_period;
        if (seq_step == '0 && tk.start_req) begin
            seq_step  = 5'd1;
            tick_div  = '0;
            shift_reg = '0;
        end
        if (seq_step != '0) begin
            phase           = seq_step - 5'd1;
            last_tick       = (int'(tick_div) + 1) >= int'(hp_eff);
            r.chip_select_n = 1'b0;
            r.busy_res      = 1'b1;
            r.serial_clock  = phase[0];
            r.serial_din    = !(phase == PHASE_ODD_LOW || phase == PHASE_ODD_HIGH);
            if (last_tick) begin
                if (phase[0] && phase >= PHASE_FIRST_DATA)
                    shift_reg = {shift_reg[SAMPLE_W-2:0], tk.adc_dout};
                if (phase == PHASE_LAST) begin
                    r.sample_valid = 1'b1;
                    r.raw_sample   = shift_reg;
                    if (!primed) begin
                        // The first sample seeds the whole window.
                        primed = 1'b1;
                        for (int i = 0; i < DEPTH; i++)
                            history[i] = shift_reg;
                        running_total     = int'(shift_reg) * DEPTH;
                        write_slot        = 0;
                        r.filtered_sample = shift_reg;
                    end else begin
                        running_total       = running_total - int'(history[write_slot])
                                              + int'(shift_reg);
                        history[write_slot] = shift_reg;
                        write_slot          = (write_slot + 1) % DEPTH;
                        r.filtered_sample   = SAMPLE_W'(running_total / DEPTH);
                    end
                    seq_step = '0;
                end else begin
                    seq_step = seq_step + 5'd1;
                end
                tick_div = '0;
            end else begin
                tick_div = tick_div + 8'd1;
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int got, input int want);
        if (got != want) begin
            $display("result %0d: %s is %0d, expected %0d", results_checked, name, got, want);
            mismatches++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive_ticks
        logic nxt_push;
        t_in  nxt_item;
        if (!i_rst_n) begin
            push   <= 1'b0;
            i_item <= '0;
        end else begin
            nxt_push = push;
            nxt_item = i_item;
            if (push && !full) begin
                predicted_outputs.push_back(convert_tick(i_item));
                ticks_sent++;
                nxt_push = 1'b0;
            end
            if (!nxt_push) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (tick_queue.size() > 0) begin
                    nxt_push = 1'b1;
                    nxt_item = tick_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            push   <= nxt_push;
            i_item <= nxt_item;
        end
    end

    // Receiver: checks every result transaction and stalls on a pattern of its own.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (!i_rst_n) begin
            pop       <= 1'b0;
            pop_cycle <= '0;
        end else begin
            if (pop && !empty) begin
                if (predicted_outputs.size() == 0) begin
                    $display("result with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = predicted_outputs.pop_front();
                    report_field("chip_select_n", o_result.chip_select_n, want.chip_select_n);
                    report_field("serial_clock", o_result.serial_clock, want.serial_clock);
                    report_field("serial_din", o_result.serial_din, want.serial_din);
                    report_field("busy_res", o_result.busy_res, want.busy_res);
                    report_field("sample_valid", o_result.sample_valid, want.sample_valid);
                    report_field("raw_sample", o_result.raw_sample, want.raw_sample);
                    report_field("filtered_sample", o_result.filtered_sample,
                                 want.filtered_sample);
                    if (want.sample_valid)
                        conversions_seen++;
                end
                results_checked++;
            end
            pop_cycle <= pop_cycle + 10'd1;
            case (pop_cycle[9:7])
                3'd0, 3'd1: pop <= 1'b1;
                3'd2:       pop <= ($urandom_range(0, 1) == 0);
                3'd3:       pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("serial_adc_reader_moving_average test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_half_period(input logic [HALF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        half_period = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_ticks(input int count, input int dout_mode, input int start_pct);
        t_in tk;
        for (int i = 0; i < count; i++) begin
            tk.start_req = ($urandom_range(0, 99) < start_pct);
            case (dout_mode)
                DOUT_ZEROS: tk.adc_dout = 1'b0;
                DOUT_ONES:  tk.adc_dout = 1'b1;
                default:    tk.adc_dout = $urandom_range(0, 1);
            endcase
            tick_queue.push_back(tk);
        end
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || push || predicted_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int hp_pick;
        int n_ticks;
        int mode;
        half_period   = HALF_PERIOD_RESET;
        seq_step      = '0;
        tick_div      = '0;
        shift_reg     = '0;
        write_slot    = 0;
        primed        = 1'b0;
        running_total = 0;
        for (int i = 0; i < DEPTH; i++)
            history[i] = '0;
        ticks_sent       = 0;
        results_checked  = 0;
        conversions_seen = 0;
        cfg_writes       = 0;
        mismatches       = 0;
        burst_left       = 0;
        gap_left         = 0;
        idle_cycles      = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A zero half period runs like one tick per level; starts while busy are ignored.
        write_half_period(8'd0);
        queue_ticks(23, DOUT_ONES, 100);
        wait_drained();

        // Shorten the half period in the middle of a phase that has already run past it.
        write_half_period(8'd6);
        queue_ticks(5, DOUT_ZEROS, 100);
        wait_drained();
        write_half_period(8'd2);

        for (int ph = 0; ph < 14; ph++) begin
            mode = $urandom_range(0, 4);
            if (mode > DOUT_ONES)
                mode = DOUT_RANDOM;
            n_ticks = $urandom_range(80, 100);
            case (ph)
                4: begin
                    // The longest half period, held across a few full levels.
                    hp_pick = 255;
                    n_ticks = 2 * 255 + 10;
                end
                9:  hp_pick = 0;
                12: hp_pick = 1;
                default: hp_pick = ($urandom_range(0, 4) == 0) ? 7 : $urandom_range(1, 4);
            endcase
            write_half_period(HALF_W'(hp_pick));
            queue_ticks(n_ticks, mode, ($urandom_range(0, 3) == 0) ? 30 : 90);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("%0d ticks driven over %0d half-period settings, %0d results checked",
                 ticks_sent, cfg_writes, results_checked);
        $display("%0d conversions completed through the averaging filter", conversions_seen);
        if (mismatches == 0)
            $display("serial_adc_reader_moving_average test passed");
        else
            $display("serial_adc_reader_moving_average test failed");
        $finish;
    end

endmodule
